>>> hdl/sfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, sizes, operation codes and helpers for the sparse frame averager.
// ----------------------------------------------------------------------------
package sfa_pkg;

  // Geometry of the pixel store.
  localparam int PIXELS     = 65536;
  localparam int IDX_W      = 16;
  localparam int MAX_FRAMES = 1024;
  localparam int FC_W       = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W      = 34;
  localparam int VAL_W      = 24;

  // The touched marks are kept as words of WORD_W bits.
  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = PIXELS / WORD_W;
  localparam int WADDR_W = $clog2(WORDS);

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        pixel_index;
    logic signed [VAL_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] average_value;
    logic                    last_pixel;
    logic                    no_result;
  } out_item_t;

  // Position of the lowest set bit of a word (zero when none is set).
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> hdl/sfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sfa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_div
// Sequential signed divider: sum by frame count, truncated toward zero, with
// the quotient saturated to the output range. One quotient bit per cycle.
// Done stays high, with the quotient held, until the next start.
// ----------------------------------------------------------------------------
module sfa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [sfa_pkg::SUM_W-1:0] dividend,
  input  logic [sfa_pkg::FC_W-1:0]      divisor,
  output logic                          done,
  output logic signed [sfa_pkg::VAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(sfa_pkg::SUM_W + 1);
  localparam logic [sfa_pkg::SUM_W-1:0] POS_LIM =
    sfa_pkg::SUM_W'((64'd1 << (sfa_pkg::VAL_W - 1)) - 64'd1);
  localparam logic [sfa_pkg::SUM_W-1:0] NEG_LIM =
    sfa_pkg::SUM_W'(64'd1 << (sfa_pkg::VAL_W - 1));

  logic                       busy;
  logic [CNT_W-1:0]           count;
  logic                       neg;
  logic [sfa_pkg::FC_W-1:0]   dvsr;
  logic [sfa_pkg::FC_W-1:0]   rem;
  logic [sfa_pkg::SUM_W-1:0]  quo;
  logic [sfa_pkg::FC_W:0]     trial;
  logic                       fits;
  logic [sfa_pkg::FC_W-1:0]   rem_next;
  logic [sfa_pkg::SUM_W-1:0]  quo_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, quo[sfa_pkg::SUM_W-1]};
    fits     = (trial >= {1'b0, dvsr});
    rem_next = fits ? sfa_pkg::FC_W'(trial - {1'b0, dvsr}) : sfa_pkg::FC_W'(trial);
    quo_next = {quo[sfa_pkg::SUM_W-2:0], fits};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        count <= CNT_W'(sfa_pkg::SUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude division, then sign and saturation on the last step.
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[sfa_pkg::SUM_W-1];
      quo  <= dividend[sfa_pkg::SUM_W-1] ? sfa_pkg::SUM_W'(-dividend)
                                         : sfa_pkg::SUM_W'(dividend);
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      if (count == CNT_W'(1)) begin
        if (!neg) begin
          quotient <= (quo_next > POS_LIM) ? sfa_pkg::VAL_W'(POS_LIM)
                                           : sfa_pkg::VAL_W'(quo_next);
        end else begin
          quotient <= (quo_next > NEG_LIM) ? sfa_pkg::VAL_W'(NEG_LIM)
                                           : sfa_pkg::VAL_W'(-quo_next);
        end
      end
    end
  end

endmodule

>>> hdl/sparse_frame_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_frame_average
// Accumulates sparse pixel entries over frames and returns per-pixel averages
// in ascending index order, clearing each pixel as it is returned.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Meaning
//  in        in_valid / in_ready / in_data    add, close frame or fetch
//  out       out_valid / out_ready / out_data one item per fetch
//
// Add reads the sum and touched word, then writes both back; close counts the
// frame. A fetch scans the touched map one 64-bit word per cycle, twice (to
// find the pixel, then to find whether another follows). The 34-step divider
// starts once the found pixel's sum has been read and runs alongside the
// second scan; the result waits for both, then passes through the pending
// register to the output register. After reset, a clearing pass zeroes the
// touched map; no item is accepted during it. A result held in the output
// register lets the next item in; only the next fetch result waits.
// ----------------------------------------------------------------------------
module sparse_frame_average (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfa_pkg::out_item_t out_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_SUMRD = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  localparam logic [sfa_pkg::WADDR_W-1:0] LAST_WORD =
    sfa_pkg::WADDR_W'(sfa_pkg::WORDS - 1);
  localparam logic signed [sfa_pkg::SUM_W:0] SUM_MAX =
    {2'b00, {(sfa_pkg::SUM_W - 1){1'b1}}};
  localparam logic signed [sfa_pkg::SUM_W:0] SUM_MIN =
    {2'b11, {(sfa_pkg::SUM_W - 1){1'b0}}};

  logic [3:0]                      state;
  logic [sfa_pkg::FC_W-1:0]        frame_count;
  logic [sfa_pkg::IDX_W-1:0]       cursor;
  logic [sfa_pkg::WADDR_W-1:0]     scan_addr;
  logic                            first_word;
  logic [sfa_pkg::IDX_W-1:0]       item_index;
  logic signed [sfa_pkg::VAL_W-1:0] item_value;
  logic [sfa_pkg::IDX_W-1:0]       found;
  logic [sfa_pkg::WORD_W-1:0]      kept_word;
  logic                            has_next;
  sfa_pkg::out_item_t              pending;

  logic                            accept;
  logic                            out_free;

  // Memory ports.
  logic                            t_we;
  logic [sfa_pkg::WADDR_W-1:0]     t_waddr;
  logic [sfa_pkg::WORD_W-1:0]      t_wdata;
  logic [sfa_pkg::WADDR_W-1:0]     t_raddr;
  logic [sfa_pkg::WORD_W-1:0]      t_rdata;
  logic                            s_we;
  logic [sfa_pkg::IDX_W-1:0]       s_waddr;
  logic [sfa_pkg::SUM_W-1:0]       s_wdata;
  logic [sfa_pkg::IDX_W-1:0]       s_raddr;
  logic [sfa_pkg::SUM_W-1:0]       s_rdata;

  // Add and scan datapath.
  logic [sfa_pkg::BIT_W-1:0]       add_bit;
  logic signed [sfa_pkg::SUM_W:0]  add_sum;
  logic [sfa_pkg::SUM_W-1:0]       add_sat;
  logic [sfa_pkg::WORD_W-1:0]      find_word;
  logic [sfa_pkg::BIT_W-1:0]       find_pos;
  logic [sfa_pkg::IDX_W-1:0]       find_index;
  logic [sfa_pkg::WORD_W-1:0]      above_word;

  logic                            div_start;
  logic                            div_done;
  logic signed [sfa_pkg::VAL_W-1:0] div_quot;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Touched marks, one word per 64 pixels.
  sfa_ram #(.WIDTH(sfa_pkg::WORD_W), .DEPTH(sfa_pkg::WORDS)) u_touched (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Pixel sums; an entry is meaningful only while its touched mark is set.
  sfa_ram #(.WIDTH(sfa_pkg::SUM_W), .DEPTH(sfa_pkg::PIXELS)) u_sum (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_rdata),
    .divisor  (frame_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Saturating accumulate of a new sample; an untouched pixel starts at zero.
  always_comb begin
    add_bit = item_index[sfa_pkg::BIT_W-1:0];
    add_sum = (t_rdata[add_bit] ? (sfa_pkg::SUM_W + 1)'(signed'(s_rdata))
                                : '0)
            + (sfa_pkg::SUM_W + 1)'(item_value);
    if (add_sum > SUM_MAX) begin
      add_sat = sfa_pkg::SUM_W'(SUM_MAX);
    end else if (add_sum < SUM_MIN) begin
      add_sat = sfa_pkg::SUM_W'(SUM_MIN);
    end else begin
      add_sat = sfa_pkg::SUM_W'(add_sum);
    end
  end

  // Scan of the word just read; the first word ignores bits below the cursor.
  always_comb begin
    find_word  = first_word
               ? (t_rdata & ({sfa_pkg::WORD_W{1'b1}} << cursor[sfa_pkg::BIT_W-1:0]))
               : t_rdata;
    find_pos   = sfa_pkg::lowest_set(find_word);
    find_index = {scan_addr, find_pos};
    above_word = kept_word & (({sfa_pkg::WORD_W{1'b1}} << found[sfa_pkg::BIT_W-1:0]) << 1);
  end

  // Memory port steering.
  always_comb begin
    t_we      = 1'b0;
    t_waddr   = scan_addr;
    t_wdata   = '0;
    t_raddr   = scan_addr;
    s_we      = 1'b0;
    s_waddr   = item_index;
    s_wdata   = add_sat;
    s_raddr   = item_index;
    div_start = 1'b0;
    case (state)
      S_CLEAR: begin
        t_we = 1'b1;
      end
      S_IDLE: begin
        s_raddr = in_data.pixel_index;
        t_raddr = (in_data.operation == sfa_pkg::OP_ADD)
                ? in_data.pixel_index[sfa_pkg::IDX_W-1:sfa_pkg::BIT_W]
                : cursor[sfa_pkg::IDX_W-1:sfa_pkg::BIT_W];
      end
      S_ADD: begin
        t_we    = 1'b1;
        t_waddr = item_index[sfa_pkg::IDX_W-1:sfa_pkg::BIT_W];
        t_wdata = t_rdata | (sfa_pkg::WORD_W'(1) << add_bit);
        s_we    = 1'b1;
      end
      S_FIND: begin
        s_raddr = find_index;
        if (|find_word) begin
          t_we    = 1'b1;
          t_wdata = t_rdata & ~(sfa_pkg::WORD_W'(1) << find_pos);
        end else begin
          t_raddr = scan_addr + 1'b1;
        end
      end
      S_SUMRD: begin
        div_start = 1'b1;
        t_raddr   = scan_addr + 1'b1;
      end
      S_NEXT: begin
        t_raddr = scan_addr + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded from the pending result, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_data  <= pending;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      scan_addr   <= '0;
      frame_count <= '0;
      cursor      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_index <= in_data.pixel_index;
            item_value <= in_data.sample_value;
            case (in_data.operation)
              sfa_pkg::OP_ADD: begin
                if ({1'b0, in_data.pixel_index} < (sfa_pkg::IDX_W + 1)'(sfa_pkg::PIXELS)) begin
                  state <= S_ADD;
                end
              end
              sfa_pkg::OP_CLOSE: begin
                if (frame_count < sfa_pkg::FC_W'(sfa_pkg::MAX_FRAMES)) begin
                  frame_count <= frame_count + 1'b1;
                end
              end
              sfa_pkg::OP_FETCH: begin
                if (frame_count == '0) begin
                  pending <= '{out_index: '0, average_value: '0,
                               last_pixel: 1'b0, no_result: 1'b1};
                  state   <= S_EMIT;
                end else begin
                  scan_addr  <= cursor[sfa_pkg::IDX_W-1:sfa_pkg::BIT_W];
                  first_word <= 1'b1;
                  state      <= S_FIND;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_FIND: begin
          first_word <= 1'b0;
          if (|find_word) begin
            found     <= find_index;
            kept_word <= t_rdata & ~(sfa_pkg::WORD_W'(1) << find_pos);
            state     <= S_SUMRD;
          end else if (scan_addr == LAST_WORD) begin
            pending     <= '{out_index: '0, average_value: '0,
                             last_pixel: 1'b0, no_result: 1'b1};
            frame_count <= '0;
            cursor      <= '0;
            state       <= S_EMIT;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_SUMRD: begin
          // Look for a later touched pixel, first in the same word.
          if (|above_word) begin
            has_next <= 1'b1;
            state    <= S_DIV;
          end else if (scan_addr == LAST_WORD) begin
            has_next <= 1'b0;
            state    <= S_DIV;
          end else begin
            scan_addr <= scan_addr + 1'b1;
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (|t_rdata) begin
            has_next <= 1'b1;
            state    <= S_DIV;
          end else if (scan_addr == LAST_WORD) begin
            has_next <= 1'b0;
            state    <= S_DIV;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pending <= '{out_index: found, average_value: div_quot,
                         last_pixel: !has_next, no_result: 1'b0};
            if (has_next) begin
              cursor <= found + 1'b1;
            end else begin
              cursor      <= '0;
              frame_count <= '0;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
